// ===== sv/cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// cmts_pkg
// Shared types and constants of the cube map texel store unit.
// ----------------------------------------------------------------------------
package cmts_pkg;

   localparam int MAX_FACE_SIDE = 64;
   localparam int FACE_COUNT    = 6;
   localparam int SIDE_BITS     = $clog2(MAX_FACE_SIDE);
   localparam int FACE_BITS     = 3;
   localparam int ADDR_BITS     = FACE_BITS + 2 * SIDE_BITS;
   localparam int STORE_DEPTH   = FACE_COUNT * MAX_FACE_SIDE * MAX_FACE_SIDE;
   localparam int SIZE_BITS     = 7;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   localparam logic CSR_FACE_WIDTH  = 1'b0;
   localparam logic CSR_FACE_HEIGHT = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [31:0] new_depth;
      logic [63:0]        new_attributes;
   } req_type;

   typedef struct packed {
      logic [2:0]         face;
      logic [5:0]         texel_x;
      logic [5:0]         texel_y;
      logic signed [31:0] stored_depth;
      logic [63:0]        stored_attributes;
      logic               hit;
      logic               error;
   } rsp_type;

endpackage

// ===== sv/cube_map_texel_store_unit.sv =====
// ----------------------------------------------------------------------------
// cube_map_texel_store_unit
// Cube map face selection, texel addressing and a depth/attribute texel store.
// ----------------------------------------------------------------------------
// One item is in work at a time and passes, from acceptance to its
// result beat: face select, numerator multiply, six steps of the shared
// bit-per-cycle divider (x and y in parallel), the memory access and the
// registered read. A zero direction goes from face select straight to the result.
// The result sits in an output register, so the next item is taken while it
// waits. After reset the depth store is cleared one entry per cycle, all 24576
// entries, with req_stall high; configuration writes are taken during it.
module cube_map_texel_store_unit
   import cmts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [SIZE_BITS-1:0] csr_wdata
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FACE  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_MEM   = 3'd5;
   localparam logic [2:0] S_READ  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam int MAG_BITS = 17;
   localparam int NUM_BITS = MAG_BITS + SIDE_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(STORE_DEPTH - 1);

   logic [2:0]            state_ff;
   logic [ADDR_BITS-1:0]  clr_addr_ff;
   logic [SIZE_BITS-1:0]  face_width_ff;
   logic [SIZE_BITS-1:0]  face_height_ff;
   req_type               req_ff;
   logic                  error_ff;
   logic [2:0]            face_ff;
   logic [MAG_BITS-1:0]   mag_ff;
   logic [MAG_BITS-1:0]   amu_ff;
   logic [MAG_BITS-1:0]   amv_ff;
   logic [NUM_BITS-1:0]   rem_u_ff;
   logic [NUM_BITS-1:0]   rem_v_ff;
   logic [SIDE_BITS-1:0]  q_u_ff;
   logic [SIDE_BITS-1:0]  q_v_ff;
   logic [2:0]            step_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic signed [31:0]    rd_depth_ff;
   logic [63:0]           rd_attr_ff;

   logic signed [31:0]    depth_mem [STORE_DEPTH];
   logic [63:0]           attr_mem  [STORE_DEPTH];

   // effective sizes, minus one
   logic [SIDE_BITS-1:0]  wm1;
   logic [SIDE_BITS-1:0]  hm1;

   always_comb begin
      if (face_width_ff == '0) begin
         wm1 = '0;
      end else if (face_width_ff > SIZE_BITS'(MAX_FACE_SIDE)) begin
         wm1 = SIDE_BITS'(MAX_FACE_SIDE - 1);
      end else begin
         wm1 = SIDE_BITS'(face_width_ff - 1'b1);
      end
      if (face_height_ff == '0) begin
         hm1 = '0;
      end else if (face_height_ff > SIZE_BITS'(MAX_FACE_SIDE)) begin
         hm1 = SIDE_BITS'(MAX_FACE_SIDE - 1);
      end else begin
         hm1 = SIDE_BITS'(face_height_ff - 1'b1);
      end
   end

   // face selection from the held direction
   logic signed [MAG_BITS-1:0] sx, sy, sz, au, av;
   logic [MAG_BITS-1:0]        ax, ay, az, m_sel;
   logic                       neg_sel;
   logic [1:0]                 axis;
   logic [2:0]                 face_sel;

   always_comb begin
      sx = MAG_BITS'(req_ff.dir_x);
      sy = MAG_BITS'(req_ff.dir_y);
      sz = MAG_BITS'(req_ff.dir_z);
      ax = sx[MAG_BITS-1] ? MAG_BITS'(-sx) : MAG_BITS'(sx);
      ay = sy[MAG_BITS-1] ? MAG_BITS'(-sy) : MAG_BITS'(sy);
      az = sz[MAG_BITS-1] ? MAG_BITS'(-sz) : MAG_BITS'(sz);
      m_sel   = ax;
      neg_sel = sx[MAG_BITS-1];
      axis    = 2'd0;
      if (ay > m_sel) begin
         m_sel   = ay;
         neg_sel = sy[MAG_BITS-1];
         axis    = 2'd1;
      end
      if (az > m_sel) begin
         m_sel   = az;
         neg_sel = sz[MAG_BITS-1];
         axis    = 2'd2;
      end
      face_sel = {axis, ~neg_sel};
      case (face_sel)
         3'd0: begin au = sz;  av = sy;  end
         3'd1: begin au = -sz; av = sy;  end
         3'd2: begin au = sx;  av = sz;  end
         3'd3: begin au = sx;  av = -sz; end
         3'd4: begin au = -sx; av = sy;  end
         default: begin au = sx; av = sy; end
      endcase
   end

   // divider step: one quotient bit per cycle for each axis
   logic [NUM_BITS:0] den_sh;
   logic [NUM_BITS:0] rem_u_ext, rem_v_ext;
   logic              take_u, take_v;

   always_comb begin
      den_sh    = (NUM_BITS + 1)'({mag_ff, 1'b0}) << step_ff;
      rem_u_ext = {1'b0, rem_u_ff};
      rem_v_ext = {1'b0, rem_v_ff};
      take_u    = rem_u_ext >= den_sh;
      take_v    = rem_v_ext >= den_sh;
   end

   logic [SIDE_BITS-1:0] tx, ty;
   logic [ADDR_BITS-1:0] addr;

   always_comb begin
      tx   = (q_u_ff > wm1) ? wm1 : q_u_ff;
      ty   = (q_v_ff > hm1) ? hm1 : q_v_ff;
      addr = {face_ff, ty, tx};
   end

   always_comb begin
      rsp_in                   = '0;
      rsp_in.error             = error_ff;
      if (!error_ff) begin
         rsp_in.face    = face_ff;
         rsp_in.texel_x = tx;
         rsp_in.texel_y = ty;
         if (req_ff.command == CMD_LOOKUP) begin
            rsp_in.stored_depth      = rd_depth_ff;
            rsp_in.stored_attributes = rd_attr_ff;
            rsp_in.hit               = rd_depth_ff > 0;
         end
      end
   end

   // memories: one write port and one registered read port each
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic signed [31:0]   mem_wdepth;

   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = addr;
      mem_wdepth = req_ff.new_depth;
      if (state_ff == S_CLEAR) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_addr_ff;
         mem_wdepth = '0;
      end else if (state_ff == S_MEM && !error_ff && req_ff.command == CMD_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wdepth;
      end
      rd_depth_ff <= depth_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MEM && !error_ff && req_ff.command == CMD_WRITE) begin
         attr_mem[addr] <= req_ff.new_attributes;
      end
      rd_attr_ff <= attr_mem[addr];
   end

   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         face_width_ff  <= SIZE_BITS'(MAX_FACE_SIDE);
         face_height_ff <= SIZE_BITS'(MAX_FACE_SIDE);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FACE_WIDTH:  face_width_ff  <= csr_wdata;
               CSR_FACE_HEIGHT: face_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         // load a finished item, or drop the beat once taken
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_payload;
                  state_ff <= S_FACE;
               end
            end
            S_FACE: begin
               error_ff <= m_sel == '0;
               face_ff  <= face_sel;
               mag_ff   <= m_sel;
               amu_ff   <= MAG_BITS'(au + $signed(m_sel));
               amv_ff   <= MAG_BITS'(av + $signed(m_sel));
               state_ff <= (m_sel == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
               rem_u_ff <= NUM_BITS'(amu_ff * wm1) + NUM_BITS'(mag_ff);
               rem_v_ff <= NUM_BITS'(amv_ff * hm1) + NUM_BITS'(mag_ff);
               step_ff  <= 3'(SIDE_BITS - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division by 2m, most significant quotient bit first
               if (take_u) begin
                  rem_u_ff <= NUM_BITS'(rem_u_ext - den_sh);
               end
               if (take_v) begin
                  rem_v_ff <= NUM_BITS'(rem_v_ext - den_sh);
               end
               q_u_ff[step_ff[$clog2(SIDE_BITS)-1:0]] <= take_u;
               q_v_ff[step_ff[$clog2(SIDE_BITS)-1:0]] <= take_v;
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= S_MEM;
               end
            end
            S_MEM: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= rsp_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("item accepted during clearing pass");
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error |-> !rsp_payload.hit && rsp_payload.face == '0)
      else $error("error beat carries texel data");
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.face < 3'(FACE_COUNT))
      else $error("face out of range");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MEM |-> $past(state_ff) == S_DIV)
      else $error("memory access without divider result");
`endif

endmodule

// ===== bench/tb_cube_map_texel_store_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cube_map_texel_store_unit
// Drives direction lookups and texel writes through the cube map texel store
// under several face sizes and random handshake pressure. A local texel store
// predicts every result beat, which is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_cube_map_texel_store_unit;
   import cmts_pkg::*;

   localparam int RANDOM_ITEMS = 1880;
   localparam int PHASES       = 7;
   localparam int CYCLE_LIMIT  = 900000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_index = CSR_FACE_WIDTH;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   cube_map_texel_store_unit dut (.*);

   always #6 clock = ~clock;

   // texel store as seen by the checker, and the sizes it was last given
   logic signed [31:0] depth_mem [STORE_DEPTH];
   logic [63:0]        attr_mem  [STORE_DEPTH];
   bit                 attr_seen [STORE_DEPTH];
   int                 size_w = 64;
   int                 size_h = 64;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      fail_count = 0;
   int      cycle_count = 0;

   function automatic int clamp_side(int s);
      if (s == 0) return 1;
      if (s > MAX_FACE_SIDE) return MAX_FACE_SIDE;
      return s;
   endfunction

   function automatic int texel_coord(int a, int m, int side);
      longint t;
      t = (longint'(a + m) * (side - 1) + m) / (2 * longint'(m));
      if (t > side - 1) t = side - 1;
      return int'(t);
   endfunction

   // face and texel of a direction; returns 0 for the zero vector
   function automatic bit locate(req_type r, output logic [2:0] f,
                                 output logic [5:0] tx, output logic [5:0] ty,
                                 output int addr);
      int x, y, z, m, comp, au, av, axis;
      x = r.dir_x; y = r.dir_y; z = r.dir_z;
      m = (x < 0) ? -x : x; comp = x; axis = 0;
      f = '0; tx = '0; ty = '0; addr = 0;
      if (((y < 0) ? -y : y) > m) begin
         axis = 1; m = (y < 0) ? -y : y; comp = y;
      end
      if (((z < 0) ? -z : z) > m) begin
         axis = 2; m = (z < 0) ? -z : z; comp = z;
      end
      if (m == 0) return 0;
      f = 3'(axis * 2 + ((comp < 0) ? 0 : 1));
      case (f)
         3'd0: begin au = z;  av = y; end
         3'd1: begin au = -z; av = y; end
         3'd2: begin au = x;  av = z; end
         3'd3: begin au = x;  av = -z; end
         3'd4: begin au = -x; av = y; end
         default: begin au = x; av = y; end
      endcase
      tx = 6'(texel_coord(au, m, clamp_side(size_w)));
      ty = 6'(texel_coord(av, m, clamp_side(size_h)));
      addr = f * MAX_FACE_SIDE * MAX_FACE_SIDE + ty * MAX_FACE_SIDE + tx;
      return 1;
   endfunction

   function automatic rsp_type texel_access(req_type r);
      rsp_type e;
      int      addr;
      e = '0;
      if (!locate(r, e.face, e.texel_x, e.texel_y, addr)) begin
         e.error = 1'b1;
         return e;
      end
      if (r.command == CMD_WRITE) begin
         depth_mem[addr] = r.new_depth;
         attr_mem[addr]  = r.new_attributes;
      end else begin
         e.stored_depth      = depth_mem[addr];
         e.stored_attributes = attr_mem[addr];
         e.hit               = depth_mem[addr] > 0;
      end
      return e;
   endfunction

   // queue an item; a lookup of a texel never written turns into a write
   task automatic queue_item(req_type r);
      logic [2:0] f;
      logic [5:0] tx, ty;
      int         addr;
      if (locate(r, f, tx, ty, addr)) begin
         if (!attr_seen[addr]) r.command = CMD_WRITE;
         if (r.command == CMD_WRITE) attr_seen[addr] = 1'b1;
      end
      pending_reqs.push_back(r);
   endtask

   function automatic logic signed [15:0] rand_comp();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return 16'sh8000;
      if (sel == 1) return 16'sh7fff;
      if (sel == 2) return '0;
      return $signed(16'($urandom)) >>> $urandom_range(0, 15);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // driver: hold a stalled beat, otherwise load the next one or idle
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         expected_rsps.push_back(texel_access(req_payload));
      if (!req_valid || !req_stall) begin
         if (!reset && pending_reqs.size() > 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
      if (rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result beat with none expected, got %p", $time, rsp_payload);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_payload.face !== e.face ||
                rsp_payload.texel_x !== e.texel_x ||
                rsp_payload.texel_y !== e.texel_y ||
                rsp_payload.stored_depth !== e.stored_depth ||
                rsp_payload.stored_attributes !== e.stored_attributes ||
                rsp_payload.hit !== e.hit || rsp_payload.error !== e.error) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_payload);
               fail_count++;
            end
         end
      end
   end

   task automatic write_size(logic idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FACE_WIDTH) size_w = value & 'h7f;
      else size_h = value & 'h7f;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      int      widths  [PHASES];
      int      heights [PHASES];
      req_type r, history[$];
      int      n;
      widths  = '{64, 0, 1, 37, 127, 64, 13};
      heights = '{64, 127, 64, 5, 0, 2, 50};
      foreach (depth_mem[i]) begin
         depth_mem[i] = '0;
         attr_mem[i]  = '0;
         attr_seen[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: axis extremes, ties, zero vector, depth extremes
      r = '0;
      queue_item(r);
      r.command = CMD_WRITE; r.dir_x = 16'sh8000; r.new_depth = 32'sh7fffffff;
      r.new_attributes = '1;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r = '0; r.command = CMD_WRITE; r.dir_x = 16'sh7fff; r.dir_y = 16'sh7fff;
      r.dir_z = 16'sh8001; r.new_depth = 32'sh80000000;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r = '0; r.command = CMD_WRITE; r.dir_y = 16'sh8000; r.dir_x = 16'sh7fff;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r = '0; r.command = CMD_WRITE; r.dir_y = 16'sh7fff; r.dir_z = 16'sh8000;
      r.new_depth = 1; r.new_attributes = 64'h5a5a_a5a5_0f0f_f0f0;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r = '0; r.command = CMD_WRITE; r.dir_z = 16'sh8000; r.dir_x = 16'sh8000;
      r.dir_y = 16'sh8000; r.new_depth = -1;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r = '0; r.command = CMD_WRITE; r.dir_z = 1; r.new_depth = 32'sh1234;
      queue_item(r); r.command = CMD_LOOKUP; queue_item(r);
      r.dir_x = -1; queue_item(r);
      r = '0; r.command = CMD_LOOKUP; r.dir_z = 16'sh7fff; r.dir_x = -16'sh7fff;
      r.dir_y = 16'sh7fff; queue_item(r);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            write_size(CSR_FACE_WIDTH, widths[p]);
            write_size(CSR_FACE_HEIGHT, heights[p]);
         end
         n = RANDOM_ITEMS / PHASES;
         for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
               send_idle_pct = 79; recv_idle_pct = 26;
            end else if (i == 0) begin
               send_idle_pct = 26; recv_idle_pct = 79;
            end else if (i == 2 * n / 3) begin
               send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (i == n / 2) drain();
            r.command        = $urandom_range(0, 1) ? CMD_WRITE : CMD_LOOKUP;
            r.new_depth      = $urandom;
            r.new_attributes = {$urandom, $urandom};
            if (history.size() > 0 && $urandom_range(0, 99) < 60) begin
               // revisit an earlier direction, often a lookup
               r.dir_x = history[$urandom_range(0, history.size() - 1)].dir_x;
               r = history[$urandom_range(0, history.size() - 1)];
               r.command = $urandom_range(0, 3) ? CMD_LOOKUP : CMD_WRITE;
               r.new_depth = $urandom;
               r.new_attributes = {$urandom, $urandom};
            end else begin
               r.dir_x = rand_comp();
               r.dir_y = $urandom_range(0, 7) ? rand_comp() : r.dir_x;
               r.dir_z = $urandom_range(0, 7) ? rand_comp() : -r.dir_y;
               if ($urandom_range(0, 63) == 0) begin
                  r.dir_x = '0; r.dir_y = '0; r.dir_z = '0;
               end
               history.push_back(r);
               if (history.size() > 64) void'(history.pop_front());
            end
            queue_item(r);
            while (pending_reqs.size() > 4) @(negedge clock);
         end
         drain();
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
